// ===== design/mrch_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrch_pkg
// Shared widths, limits and types for the masked region channel histogram.
// ----------------------------------------------------------------------------
package mrch_pkg;

  localparam int PIX_W      = 12;   // coordinate and box register width
  localparam int VAL_W      = 8;    // one color channel
  localparam int CNT_W      = 24;   // bin and pixel counters
  localparam int SUM_W      = 32;   // bin sums
  localparam int CH_W       = 2;    // channel field
  localparam int BIN_OUT_W  = 2;    // bin field of a result
  localparam int CHANNELS   = 3;
  localparam int VAL_RANGE  = 256;  // number of channel codes
  localparam int BINS_DEF   = 4;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [CH_W-1:0]  CH_LAST = CH_W'(CHANNELS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT   = 2'd0,
    CFG_TOP    = 2'd1,
    CFG_RIGHT  = 2'd2,
    CFG_BOTTOM = 2'd3
  } cfg_reg_t;

  // Handoff of a finished scan from the accumulator to the result stage.
  typedef struct packed {
    logic             load;
    logic [CNT_W-1:0] total;
  } snap_ctl_t;

endpackage : mrch_pkg
`default_nettype wire

// ===== design/mrch_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrch_pix_if / mrch_res_if
// Valid/ready channels for pixels in and histogram results out.
// ----------------------------------------------------------------------------
interface mrch_pix_if;
  import mrch_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;
  logic             changed;
  logic             excluded;
  logic [VAL_W-1:0] blue;
  logic [VAL_W-1:0] green;
  logic [VAL_W-1:0] red;
  logic             scan_end;

  modport source (output valid, pixel_x, pixel_y, changed, excluded, blue, green, red,
                  scan_end, input ready);
  modport sink   (input valid, pixel_x, pixel_y, changed, excluded, blue, green, red,
                  scan_end, output ready);
endinterface : mrch_pix_if

interface mrch_res_if;
  import mrch_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CH_W-1:0]      channel;
  logic [BIN_OUT_W-1:0] bin;
  logic [CNT_W-1:0]     bin_count;
  logic [SUM_W-1:0]     bin_sum;
  logic [CNT_W-1:0]     total_pixels;
  logic                 final_res;

  modport source (output valid, channel, bin, bin_count, bin_sum, total_pixels, final_res,
                  input ready);
  modport sink   (input valid, channel, bin, bin_count, bin_sum, total_pixels, final_res,
                  output ready);
endinterface : mrch_res_if
`default_nettype wire

// ===== design/mrch_accum.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrch_accum
// Input register, region qualification, bin lookup and the saturating
// count/sum store. Hands a completed scan to the result stage.
// ----------------------------------------------------------------------------
module mrch_accum #(
  parameter int  BINS  = mrch_pkg::BINS_DEF,
  localparam int SLOTS = mrch_pkg::CHANNELS * BINS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  mrch_pix_if.sink                           in_pix,
  input  wire logic [mrch_pkg::PIX_W-1:0]    region_left,
  input  wire logic [mrch_pkg::PIX_W-1:0]    region_top,
  input  wire logic [mrch_pkg::PIX_W-1:0]    region_right,
  input  wire logic [mrch_pkg::PIX_W-1:0]    region_bottom,
  input  wire logic                          snap_free,
  output mrch_pkg::snap_ctl_t                snap_ctl,
  output logic [mrch_pkg::CNT_W-1:0]         snap_cnt [SLOTS],
  output logic [mrch_pkg::SUM_W-1:0]         snap_sum [SLOTS]
);
  import mrch_pkg::*;

  localparam int BIN_W = (BINS > 1) ? $clog2(BINS) : 1;

  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_x_r;
  logic [PIX_W-1:0] s1_y_r;
  logic             s1_chg_r;
  logic             s1_exc_r;
  logic             s1_end_r;
  logic [VAL_W-1:0] s1_val_r [CHANNELS];

  logic [CNT_W-1:0] cnt_r   [SLOTS];
  logic [CNT_W-1:0] cnt_nxt [SLOTS];
  logic [SUM_W-1:0] sum_r   [SLOTS];
  logic [SUM_W-1:0] sum_nxt [SLOTS];
  logic [CNT_W-1:0] total_r;
  logic [CNT_W-1:0] total_nxt;

  logic             s1_adv;
  logic             in_rdy;
  logic             qual;
  logic [BIN_W-1:0] bin_sel [CHANNELS];

  // A scan end can only leave stage 1 once the result stage can take the snapshot.
  assign s1_adv       = s1_valid_r && (!s1_end_r || snap_free);
  assign in_rdy       = !s1_valid_r || s1_adv;
  assign in_pix.ready = in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_rdy) begin
      s1_valid_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_pix.valid) begin
      s1_x_r      <= in_pix.pixel_x;
      s1_y_r      <= in_pix.pixel_y;
      s1_chg_r    <= in_pix.changed;
      s1_exc_r    <= in_pix.excluded;
      s1_end_r    <= in_pix.scan_end;
      s1_val_r[0] <= in_pix.blue;
      s1_val_r[1] <= in_pix.green;
      s1_val_r[2] <= in_pix.red;
    end
  end

  assign qual = s1_valid_r && s1_chg_r && !s1_exc_r &&
                (s1_x_r > region_left) && (s1_x_r < region_right) &&
                (s1_y_r > region_top)  && (s1_y_r < region_bottom);

  assign total_nxt = (qual && total_r != CNT_MAX) ? total_r + CNT_W'(1) : total_r;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    logic [BINS-1:0] below;

    for (genvar b = 0; b < BINS; b++) begin : g_bound
      localparam int BOUND = ((b + 1) * VAL_RANGE) / BINS;
      assign below[b] = {1'b0, s1_val_r[c]} < (VAL_W + 1)'(BOUND);
    end

    // The lowest bin whose upper bound exceeds the value wins.
    always_comb begin
      bin_sel[c] = BIN_W'(BINS - 1);
      for (int b = BINS - 1; b >= 0; b--) begin
        if (below[b]) begin
          bin_sel[c] = BIN_W'(b);
        end
      end
    end

    for (genvar b = 0; b < BINS; b++) begin : g_slot
      localparam int S = c * BINS + b;
      logic             hit;
      logic [SUM_W:0]   sum_ext;

      assign hit     = qual && (bin_sel[c] == BIN_W'(b));
      assign sum_ext = {1'b0, sum_r[S]} + (SUM_W + 1)'(s1_val_r[c]);

      always_comb begin
        cnt_nxt[S] = cnt_r[S];
        sum_nxt[S] = sum_r[S];
        if (hit) begin
          if (cnt_r[S] != CNT_MAX) begin
            cnt_nxt[S] = cnt_r[S] + CNT_W'(1);
          end
          sum_nxt[S] = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
        end
      end
    end
  end

  // The scan end pixel is folded in before the snapshot, then the store restarts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        cnt_r[s] <= '0;
        sum_r[s] <= '0;
      end
    end else if (s1_adv) begin
      if (s1_end_r) begin
        total_r <= '0;
        for (int s = 0; s < SLOTS; s++) begin
          cnt_r[s] <= '0;
          sum_r[s] <= '0;
        end
      end else begin
        total_r <= total_nxt;
        cnt_r   <= cnt_nxt;
        sum_r   <= sum_nxt;
      end
    end
  end

  assign snap_ctl.load  = s1_adv && s1_end_r;
  assign snap_ctl.total = total_nxt;
  assign snap_cnt       = cnt_nxt;
  assign snap_sum       = sum_nxt;

endmodule : mrch_accum
`default_nettype wire

// ===== design/mrch_dump.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrch_dump
// Holds the snapshot of a finished scan and shifts it out, one result per
// transaction, through the output register.
// ----------------------------------------------------------------------------
module mrch_dump #(
  parameter int  BINS  = mrch_pkg::BINS_DEF,
  localparam int SLOTS = mrch_pkg::CHANNELS * BINS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire mrch_pkg::snap_ctl_t       snap_ctl,
  input  wire logic [mrch_pkg::CNT_W-1:0] snap_cnt [SLOTS],
  input  wire logic [mrch_pkg::SUM_W-1:0] snap_sum [SLOTS],
  output logic                           snap_free,
  mrch_res_if.source                     out_res
);
  import mrch_pkg::*;

  localparam int BIN_W  = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int BIN_CW = (BIN_W > BIN_OUT_W) ? BIN_W : BIN_OUT_W;

  logic                 busy_r;
  logic [CH_W-1:0]      ch_r;
  logic [BIN_CW-1:0]    bin_r;
  logic [CNT_W-1:0]     sh_cnt_r [SLOTS];
  logic [SUM_W-1:0]     sh_sum_r [SLOTS];
  logic [CNT_W-1:0]     total_r;

  logic                 out_valid_r;
  logic [CH_W-1:0]      out_ch_r;
  logic [BIN_OUT_W-1:0] out_bin_r;
  logic [CNT_W-1:0]     out_cnt_r;
  logic [SUM_W-1:0]     out_sum_r;
  logic [CNT_W-1:0]     out_total_r;
  logic                 out_final_r;

  logic                 bin_last;
  logic                 last;
  logic                 emit;

  assign bin_last  = (bin_r == BIN_CW'(BINS - 1));
  assign last      = bin_last && (ch_r == CH_LAST);
  assign emit      = busy_r && (!out_valid_r || out_res.ready);
  assign snap_free = !busy_r || (emit && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      ch_r        <= '0;
      bin_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end

      if (snap_ctl.load) begin
        busy_r <= 1'b1;
        ch_r   <= '0;
        bin_r  <= '0;
      end else if (emit) begin
        if (last) begin
          busy_r <= 1'b0;
        end
        if (bin_last) begin
          bin_r <= '0;
          ch_r  <= ch_r + CH_W'(1);
        end else begin
          bin_r <= bin_r + BIN_CW'(1);
        end
      end
    end
  end

  // Slot 0 always holds the next result; the line moves down on each send.
  always_ff @(posedge clk) begin
    if (snap_ctl.load) begin
      sh_cnt_r <= snap_cnt;
      sh_sum_r <= snap_sum;
      total_r  <= snap_ctl.total;
    end else if (emit) begin
      for (int s = 0; s < SLOTS - 1; s++) begin
        sh_cnt_r[s] <= sh_cnt_r[s+1];
        sh_sum_r[s] <= sh_sum_r[s+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ch_r    <= ch_r;
      out_bin_r   <= bin_r[BIN_OUT_W-1:0];
      out_cnt_r   <= sh_cnt_r[0];
      out_sum_r   <= sh_sum_r[0];
      out_total_r <= total_r;
      out_final_r <= last;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.channel      = out_ch_r;
  assign out_res.bin          = out_bin_r;
  assign out_res.bin_count    = out_cnt_r;
  assign out_res.bin_sum      = out_sum_r;
  assign out_res.total_pixels = out_total_r;
  assign out_res.final_res    = out_final_r;

endmodule : mrch_dump
`default_nettype wire

// ===== design/masked_region_channel_histogram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// masked_region_channel_histogram
// Per-channel binned pixel counts and sums over a masked region box.
//
//   channel   direction  content
//   in_pix    sink       pixel: coordinates, flags, blue/green/red, scan_end
//   out_res   source     one bin result: channel, bin, count, sum, total
//   cfg_*     write      region box edges, register index 0..3
//
// One pixel is taken per clock unless a held scan end stalls the input register;
// each pixel is registered there before it updates the store. A scan end copies
// the store into the result shift line, which sends 3*BINS results, one per clock
// while out_res is ready; pixels of the next scan keep flowing meanwhile. A second
// scan end waits in the input register until the last result of the previous
// scan has entered the output register.
// Reset clears the box and the store.
// ----------------------------------------------------------------------------
module masked_region_channel_histogram #(
  parameter int BINS = mrch_pkg::BINS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  mrch_pix_if.sink                            in_pix,
  mrch_res_if.source                          out_res,
  input  wire logic                           cfg_we,
  input  wire logic [mrch_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [mrch_pkg::PIX_W-1:0]     cfg_wdata
);
  import mrch_pkg::*;

  localparam int SLOTS = CHANNELS * BINS;

  logic [PIX_W-1:0] left_r;
  logic [PIX_W-1:0] top_r;
  logic [PIX_W-1:0] right_r;
  logic [PIX_W-1:0] bottom_r;

  snap_ctl_t        snap_ctl;
  logic             snap_free;
  logic [CNT_W-1:0] snap_cnt [SLOTS];
  logic [SUM_W-1:0] snap_sum [SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      right_r  <= '0;
      bottom_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        CFG_LEFT:   left_r   <= cfg_wdata;
        CFG_TOP:    top_r    <= cfg_wdata;
        CFG_RIGHT:  right_r  <= cfg_wdata;
        CFG_BOTTOM: bottom_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mrch_accum #(.BINS(BINS)) u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_pix        (in_pix),
    .region_left   (left_r),
    .region_top    (top_r),
    .region_right  (right_r),
    .region_bottom (bottom_r),
    .snap_free     (snap_free),
    .snap_ctl      (snap_ctl),
    .snap_cnt      (snap_cnt),
    .snap_sum      (snap_sum)
  );

  mrch_dump #(.BINS(BINS)) u_dump (
    .clk       (clk),
    .rst_n     (rst_n),
    .snap_ctl  (snap_ctl),
    .snap_cnt  (snap_cnt),
    .snap_sum  (snap_sum),
    .snap_free (snap_free),
    .out_res   (out_res)
  );

endmodule : masked_region_channel_histogram
`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the masked region channel histogram. A short table of
// directed pixels and box settings runs first, then random scans under
// several box shapes. The bench keeps its own copy of the box and the bin
// store, predicts every bin result and compares it field by field while
// both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import mrch_pkg::*;

  localparam int N_BINS      = BINS_DEF;
  localparam int SLOTS       = CHANNELS * N_BINS;
  localparam int RAND_PHASES = 5;
  localparam int PHASE_ITEMS = 50;
  localparam int SETTLE      = 4;
  localparam int TAIL        = 16;
  localparam int STUCK_LIMIT = 2000;
  localparam int MAX_REPORTS = 40;
  localparam int DIR_ROWS    = 23;
  localparam int COORD_MAX   = (1 << PIX_W) - 1;
  localparam int VAL_MAX     = (1 << VAL_W) - 1;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic             changed;
    logic             excluded;
    logic [VAL_W-1:0] blue;
    logic [VAL_W-1:0] green;
    logic [VAL_W-1:0] red;
    logic             scan_end;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0]      channel;
    logic [BIN_OUT_W-1:0] bin;
    logic [CNT_W-1:0]     count;
    logic [SUM_W-1:0]     sum;
    logic [CNT_W-1:0]     total;
    logic                 final_res;
  } bin_result_t;

  typedef enum logic {ROW_PIX, ROW_BOX} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] bottom;
    pixel_t           pix;
    logic             expect_empty;
  } dir_row_t;

  typedef enum int {SHAPE_FULL, SHAPE_WIDE, SHAPE_NARROW, SHAPE_INVERTED, SHAPE_ANY}
    box_shape_t;
  typedef enum int {RX_ALWAYS, RX_COIN, RX_SKIP, RX_LONG} rx_mode_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  cfg_reg_t         cfg_idx;
  logic [PIX_W-1:0] cfg_wdata;
  logic             drv_expect_empty;

  mrch_pix_if pix_ch ();
  mrch_res_if res_ch ();

  masked_region_channel_histogram #(.BINS(N_BINS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Rows with expect_empty set must produce twelve all-zero bins.
  dir_row_t directed_rows [DIR_ROWS] = '{
    // box is all zero after reset, so nothing qualifies
    '{ROW_PIX, '0, '0, '0, '0, '{12'd1, 12'd1, 1'b1, 1'b0, 8'd255, 8'd255, 8'd255, 1'b1}, 1'b1},
    '{ROW_BOX, 12'd0, 12'd0, 12'd4095, 12'd4095, '0, 1'b0},
    '{ROW_PIX, '0, '0, '0, '0, '{12'd0, 12'd5, 1'b1, 1'b0, 8'd10, 8'd20, 8'd30, 1'b0}, 1'b0},
    '{ROW_PIX, '0, '0, '0, '0, '{12'd4095, 12'd5, 1'b1, 1'b0, 8'd10, 8'd20, 8'd30, 1'b0}, 1'b0},
    '{ROW_PIX, '0, '0, '0, '0, '{12'd5, 12'd0, 1'b1, 1'b0, 8'd10, 8'd20, 8'd30, 1'b0}, 1'b0},
    '{ROW_PIX, '0, '0, '0, '0, '{12'd5, 12'd4095, 1'b1, 1'b0, 8'd10, 8'd20, 8'd30, 1'b0}, 1'b0},
    '{ROW_PIX, '0, '0, '0, '0, '{12'd1, 12'd1, 1'b1, 1'b1, 8'd40, 8'd50, 8'd60, 1'b0}, 1'b0},
    '{ROW_PIX, '0, '0, '0, '0, '{12'd1, 12'd1, 1'b0, 1'b0, 8'd40, 8'd50, 8'd60, 1'b0}, 1'b0},
    '{ROW_PIX, '0, '0, '0, '0, '{12'd1, 12'd1, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0}, 1'b0},
    '{ROW_PIX, '0, '0, '0, '0, '{12'd4094, 12'd4094, 1'b1, 1'b0, 8'd255, 8'd255, 8'd255, 1'b0},
      1'b0},
    // values on both sides of the bin boundaries
    '{ROW_PIX, '0, '0, '0, '0, '{12'd2000, 12'd3000, 1'b1, 1'b0, 8'd63, 8'd64, 8'd127, 1'b0},
      1'b0},
    '{ROW_PIX, '0, '0, '0, '0, '{12'd1234, 12'd2345, 1'b1, 1'b0, 8'd128, 8'd191, 8'd192, 1'b1},
      1'b0},
    // fresh scan whose only pixel is excluded
    '{ROW_PIX, '0, '0, '0, '0, '{12'd7, 12'd7, 1'b1, 1'b1, 8'd5, 8'd6, 8'd7, 1'b1}, 1'b1},
    '{ROW_BOX, 12'd100, 12'd100, 12'd50, 12'd200, '0, 1'b0},
    '{ROW_PIX, '0, '0, '0, '0, '{12'd75, 12'd150, 1'b1, 1'b0, 8'd1, 8'd2, 8'd3, 1'b1}, 1'b1},
    '{ROW_BOX, 12'd0, 12'd300, 12'd4095, 12'd300, '0, 1'b0},
    '{ROW_PIX, '0, '0, '0, '0, '{12'd5, 12'd300, 1'b1, 1'b0, 8'd9, 8'd99, 8'd199, 1'b1}, 1'b1},
    '{ROW_BOX, 12'd4095, 12'd4095, 12'd0, 12'd0, '0, 1'b0},
    '{ROW_PIX, '0, '0, '0, '0, '{12'd2048, 12'd2048, 1'b1, 1'b0, 8'd77, 8'd88, 8'd99, 1'b1},
      1'b1},
    // a box that admits exactly one pixel position
    '{ROW_BOX, 12'd99, 12'd99, 12'd101, 12'd101, '0, 1'b0},
    '{ROW_PIX, '0, '0, '0, '0, '{12'd101, 12'd100, 1'b1, 1'b0, 8'd11, 8'd22, 8'd33, 1'b0}, 1'b0},
    '{ROW_PIX, '0, '0, '0, '0, '{12'd100, 12'd100, 1'b1, 1'b0, 8'd200, 8'd100, 8'd50, 1'b1},
      1'b0},
    '{ROW_PIX, '0, '0, '0, '0, '{12'd100, 12'd100, 1'b1, 1'b0, 8'd255, 8'd0, 8'd255, 1'b0}, 1'b0}
  };

  // Bench copy of the box and the bin store.
  logic [PIX_W-1:0] box_left   = '0;
  logic [PIX_W-1:0] box_top    = '0;
  logic [PIX_W-1:0] box_right  = '0;
  logic [PIX_W-1:0] box_bottom = '0;
  logic [CNT_W-1:0] bin_counts [SLOTS];
  logic [SUM_W-1:0] bin_sums   [SLOTS];
  logic [CNT_W-1:0] region_total = '0;
  bin_result_t      pending_bins [$];

  int mismatches       = 0;
  int pixels_taken     = 0;
  int pixels_qualified = 0;
  int scans_closed     = 0;
  int results_seen     = 0;
  int boxes_written    = 0;
  int stuck_cycles     = 0;
  int burst_left       = 0;
  int rx_tick          = 0;
  rx_mode_t rx_mode    = RX_ALWAYS;

  initial begin
    foreach (bin_counts[i]) begin
      bin_counts[i] = '0;
      bin_sums[i]   = '0;
    end
  end

  task automatic note_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic cmp_field(input string name, input logic [SUM_W-1:0] got,
                           input logic [SUM_W-1:0] exp, input bin_result_t want);
    if (got !== exp)
      note_mismatch($sformatf("channel %0d bin %0d %s: got %0d, expected %0d",
                              want.channel, want.bin, name, got, exp));
  endtask

  function automatic int bin_index(input logic [VAL_W-1:0] v);
    for (int b = 0; b < N_BINS; b++)
      if (int'(v) < (b + 1) * VAL_RANGE / N_BINS) return b;
    return N_BINS - 1;
  endfunction

  // Accounts one accepted pixel; on a scan end queues the twelve bin results
  // in channel-major order and clears the store.
  task automatic tally_pixel(input pixel_t p, input logic expect_empty);
    logic [VAL_W-1:0] vals [CHANNELS];
    logic [SUM_W:0]   wide;
    int               slot;
    bin_result_t      r;
    vals[0] = p.blue;
    vals[1] = p.green;
    vals[2] = p.red;
    pixels_taken++;
    if (p.x > box_left && p.x < box_right && p.y > box_top && p.y < box_bottom &&
        p.changed && !p.excluded) begin
      pixels_qualified++;
      if (region_total != CNT_MAX) region_total++;
      for (int c = 0; c < CHANNELS; c++) begin
        slot = c * N_BINS + bin_index(vals[c]);
        if (bin_counts[slot] != CNT_MAX) bin_counts[slot]++;
        wide = {1'b0, bin_sums[slot]} + vals[c];
        bin_sums[slot] = wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
      end
    end
    if (p.scan_end) begin
      scans_closed++;
      for (int c = 0; c < CHANNELS; c++) begin
        for (int b = 0; b < N_BINS; b++) begin
          slot        = c * N_BINS + b;
          r.channel   = CH_W'(c);
          r.bin       = BIN_OUT_W'(b);
          r.count     = expect_empty ? '0 : bin_counts[slot];
          r.sum       = expect_empty ? '0 : bin_sums[slot];
          r.total     = expect_empty ? '0 : region_total;
          r.final_res = (slot == SLOTS - 1);
          pending_bins.insert(pending_bins.size(), r);
        end
      end
      foreach (bin_counts[i]) begin
        bin_counts[i] = '0;
        bin_sums[i]   = '0;
      end
      region_total = '0;
    end
  endtask

  always @(posedge clk) begin : monitor
    bin_result_t want;
    pixel_t      seen;
    logic        moved;
    if (rst_n) begin
      moved = 1'b0;
      if (res_ch.valid && res_ch.ready) begin
        moved = 1'b1;
        results_seen++;
        if (pending_bins.size() == 0) begin
          note_mismatch($sformatf("unexpected result: channel %0d bin %0d",
                                  res_ch.channel, res_ch.bin));
        end else begin
          want = pending_bins.pop_front();
          cmp_field("channel", SUM_W'(res_ch.channel), SUM_W'(want.channel), want);
          cmp_field("bin", SUM_W'(res_ch.bin), SUM_W'(want.bin), want);
          cmp_field("bin_count", SUM_W'(res_ch.bin_count), SUM_W'(want.count), want);
          cmp_field("bin_sum", res_ch.bin_sum, want.sum, want);
          cmp_field("total_pixels", SUM_W'(res_ch.total_pixels), SUM_W'(want.total), want);
          cmp_field("final_res", SUM_W'(res_ch.final_res), SUM_W'(want.final_res), want);
        end
      end
      if (pix_ch.valid && pix_ch.ready) begin
        moved = 1'b1;
        seen = '{pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.changed, pix_ch.excluded,
                 pix_ch.blue, pix_ch.green, pix_ch.red, pix_ch.scan_end};
        tally_pixel(seen, drv_expect_empty);
      end
      if (cfg_we) begin
        moved = 1'b1;
        case (cfg_idx)
          CFG_LEFT:   box_left   = cfg_wdata;
          CFG_TOP:    box_top    = cfg_wdata;
          CFG_RIGHT:  box_right  = cfg_wdata;
          CFG_BOTTOM: box_bottom = cfg_wdata;
          default: ;
        endcase
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
    end
  end

  // The result side periodically switches at random between four ready patterns.
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 96 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_ALWAYS: res_ch.ready <= 1'b1;
      RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
      RX_SKIP:   res_ch.ready <= (rx_tick % 4) != 3;
      default:   res_ch.ready <= (rx_tick % 16) < 6;
    endcase
  end

  initial begin : watchdog
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("Timeout: no transaction for %0d cycles", STUCK_LIMIT);
    $display("** masked_region_channel_histogram: FAILED **");
    $finish;
  end

  // Drives one pixel and returns at the edge where it is accepted. Pixels go
  // out in bursts; about one burst in four follows its predecessor with no gap.
  task automatic send_pixel(input pixel_t p, input logic expect_empty);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 5);
    end
    @(negedge clk);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_ch.valid     <= 1'b1;
    pix_ch.pixel_x   <= p.x;
    pix_ch.pixel_y   <= p.y;
    pix_ch.changed   <= p.changed;
    pix_ch.excluded  <= p.excluded;
    pix_ch.blue      <= p.blue;
    pix_ch.green     <= p.green;
    pix_ch.red       <= p.red;
    pix_ch.scan_end  <= p.scan_end;
    drv_expect_empty <= expect_empty;
    do @(posedge clk); while (!pix_ch.ready);
    burst_left--;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [PIX_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
  endtask

  // The box is only rewritten once every result has drained and the last
  // pixel has left the pipeline.
  task automatic write_box(input logic [PIX_W-1:0] l, t, r, b);
    @(negedge clk);
    pix_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
    write_reg(CFG_LEFT, l);
    write_reg(CFG_TOP, t);
    write_reg(CFG_RIGHT, r);
    write_reg(CFG_BOTTOM, b);
    @(negedge clk);
    cfg_we <= 1'b0;
    boxes_written++;
  endtask

  task automatic pick_box(input box_shape_t shape, output int l, t, r, b);
    case (shape)
      SHAPE_FULL: begin
        l = 0;
        t = 0;
        r = COORD_MAX;
        b = COORD_MAX;
      end
      SHAPE_WIDE: begin
        l = $urandom_range(0, 1000);
        t = $urandom_range(0, 1000);
        r = $urandom_range(3000, COORD_MAX);
        b = $urandom_range(3000, COORD_MAX);
      end
      SHAPE_NARROW: begin
        l = $urandom_range(0, COORD_MAX - 15);
        t = $urandom_range(0, COORD_MAX - 15);
        r = l + $urandom_range(2, 14);
        b = t + $urandom_range(2, 14);
      end
      SHAPE_INVERTED: begin
        l = $urandom_range(1, COORD_MAX);
        r = $urandom_range(0, l);
        t = $urandom_range(0, COORD_MAX);
        b = $urandom_range(0, COORD_MAX);
      end
      default: begin
        l = $urandom_range(0, COORD_MAX);
        t = $urandom_range(0, COORD_MAX);
        r = $urandom_range(0, COORD_MAX);
        b = $urandom_range(0, COORD_MAX);
      end
    endcase
  endtask

  // Mostly strictly inside the box, sometimes on or next to an edge, and
  // sometimes anywhere in the frame.
  function automatic logic [PIX_W-1:0] pick_coord(input int lo, input int hi);
    if (hi - lo < 2 || $urandom_range(0, 7) == 0) return PIX_W'($urandom_range(0, COORD_MAX));
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0:       return PIX_W'(lo);
        1:       return PIX_W'(hi);
        2:       return PIX_W'(lo + 1);
        default: return PIX_W'(hi - 1);
      endcase
    end
    return PIX_W'($urandom_range(lo + 1, hi - 1));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? VAL_W'(VAL_MAX) : '0;
    return VAL_W'($urandom_range(0, VAL_MAX));
  endfunction

  function automatic pixel_t random_pixel(input int l, t, r, b);
    pixel_t p;
    p.x        = pick_coord(l, r);
    p.y        = pick_coord(t, b);
    p.changed  = ($urandom_range(0, 7) != 0);
    p.excluded = ($urandom_range(0, 7) == 0);
    p.blue     = pick_value();
    p.green    = pick_value();
    p.red      = pick_value();
    p.scan_end = ($urandom_range(0, 11) == 0);
    return p;
  endfunction

  initial begin : stimulus
    int l, t, r, b;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_LEFT;
    cfg_wdata        = '0;
    drv_expect_empty = 1'b0;
    pix_ch.valid     = 1'b0;
    pix_ch.pixel_x   = '0;
    pix_ch.pixel_y   = '0;
    pix_ch.changed   = 1'b0;
    pix_ch.excluded  = 1'b0;
    pix_ch.blue      = '0;
    pix_ch.green     = '0;
    pix_ch.red       = '0;
    pix_ch.scan_end  = 1'b0;
    res_ch.ready     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_BOX)
        write_box(directed_rows[i].left, directed_rows[i].top,
                  directed_rows[i].right, directed_rows[i].bottom);
      else
        send_pixel(directed_rows[i].pix, directed_rows[i].expect_empty);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      pick_box(box_shape_t'(ph), l, t, r, b);
      write_box(PIX_W'(l), PIX_W'(t), PIX_W'(r), PIX_W'(b));
      repeat (PHASE_ITEMS) send_pixel(random_pixel(l, t, r, b), 1'b0);
    end

    @(negedge clk);
    pix_ch.valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    $display("Sent %0d pixels, %0d inside the region, over %0d box settings.",
             pixels_taken, pixels_qualified, boxes_written);
    $display("Closed %0d scans and checked %0d bin results; %0d mismatches.",
             scans_closed, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("** masked_region_channel_histogram: PASSED **");
    end else begin
      $display("** masked_region_channel_histogram: FAILED **");
    end
    $finish;
  end

endmodule : tb_top
